@@ sv/utf8_stream_decoder_assert.svh @@
// Assertion macros shared by the decoder modules.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Plain property, checked out of reset.
`define UTF8D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication in the same cycle, checked out of reset.
`define UTF8D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/utf8d_pkg.sv @@
// Types, constants and helper functions of the UTF-8 stream decoder.
`default_nettype none
package utf8d_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] LeadMin    = 8'hC0;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead5Min   = 8'hF8;
  localparam logic [7:0] Lead6Min   = 8'hFC;
  localparam logic [7:0] NonLeadMin = 8'hFE;
  localparam logic [7:0] ContMark   = 8'h80;
  localparam logic [7:0] LeadMask   = 8'h7F;

  // One queue entry: raw bytes to replay first, then an optional final value.
  typedef struct packed {
    logic [2:0]  flush_n;  // lead plus flush_n-1 continuation bytes, 0 = none
    logic [7:0]  lead;
    logic [29:0] payload;  // oldest continuation in the highest used six-bit group
    logic        tail_v;
    logic [30:0] tail;
  } utf8d_job_t;

  function automatic logic [2:0] needed_for(input logic [7:0] b);
    logic [2:0] n;
    if (b < Lead3Min) n = 3'd1;
    else if (b < Lead4Min) n = 3'd2;
    else if (b < Lead5Min) n = 3'd3;
    else if (b < Lead6Min) n = 3'd4;
    else n = 3'd5;
    return n;
  endfunction

  // Assemble the code point from the lead's data bits and k continuation groups.
  function automatic logic [30:0] decode_cp(input logic [7:0] lead, input logic [2:0] k,
                                            input logic [29:0] payload);
    logic [7:0]  lbits;
    logic [30:0] hi;
    lbits = lead & (LeadMask >> (k + 3'd1));
    hi    = 31'(lbits) << (6 * k);
    return hi | 31'(payload);
  endfunction

endpackage
`default_nettype wire

@@ sv/utf8d_front.sv @@
// Front end: accepts bytes, tracks the pending sequence, queues result jobs.
`default_nettype none
`include "utf8_stream_decoder_assert.svh"
module utf8d_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [7:0]            in_byte_i,
  input  wire                   end_of_string_i,
  input  wire                   q_full_i,
  output logic                  push_o,
  output utf8d_pkg::utf8d_job_t job_o
);
  import utf8d_pkg::*;

  logic [7:0]  lead_q, lead_d;
  logic [2:0]  need_q, need_d;
  logic [2:0]  rcv_q, rcv_d;
  logic [29:0] pay_q, pay_d;
  logic        accept;
  logic [2:0]  rcv_inc;
  logic [29:0] pay_inc;
  logic        fresh;
  utf8d_job_t  job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign rcv_inc    = rcv_q + 3'd1;
  assign pay_inc    = {pay_q[23:0], in_byte_i[5:0]};

  always_comb begin
    lead_d = lead_q;
    need_d = need_q;
    rcv_d  = rcv_q;
    pay_d  = pay_q;
    job    = '0;
    fresh  = 1'b1;
    if (need_q != 3'd0) begin
      if (in_byte_i[7:6] == 2'b10) begin
        fresh  = 1'b0;
        rcv_d  = rcv_inc;
        pay_d  = pay_inc;
        if (rcv_inc >= need_q) begin
          job.tail_v = 1'b1;
          job.tail   = decode_cp(lead_q, need_q, pay_inc);
          need_d     = 3'd0;
        end else if (end_of_string_i) begin
          // replay lead and every continuation, this one included
          job.flush_n = rcv_inc + 3'd1;
          job.lead    = lead_q;
          job.payload = pay_inc;
          need_d      = 3'd0;
        end
      end else begin
        // broken sequence: replay what was held, then treat this byte afresh
        job.flush_n = rcv_q + 3'd1;
        job.lead    = lead_q;
        job.payload = pay_q;
        need_d      = 3'd0;
      end
    end
    if (fresh) begin
      if (in_byte_i < LeadMin || in_byte_i >= NonLeadMin || end_of_string_i) begin
        job.tail_v = 1'b1;
        job.tail   = 31'(in_byte_i);
      end else begin
        lead_d = in_byte_i;
        need_d = needed_for(in_byte_i);
        rcv_d  = 3'd0;
        pay_d  = '0;
      end
    end
    if (end_of_string_i || need_d == 3'd0) begin
      lead_d = '0;
      need_d = 3'd0;
      rcv_d  = 3'd0;
      pay_d  = '0;
    end
  end

  assign push_o = accept && (job.flush_n != 3'd0 || job.tail_v);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      need_q <= 3'd0;
      rcv_q  <= 3'd0;
      pay_q  <= '0;
    end else if (accept) begin
      lead_q <= lead_d;
      need_q <= need_d;
      rcv_q  <= rcv_d;
      pay_q  <= pay_d;
    end
  end

  `UTF8D_ASSERT_IMP(a_rcv_below_need, clk_i, rst_ni, need_q != 3'd0, rcv_q < need_q,
                    "pending sequence already complete")
  `UTF8D_ASSERT_IMP(a_idle_clear, clk_i, rst_ni, need_q == 3'd0, rcv_q == 3'd0,
                    "continuation count without pending lead")
  `UTF8D_ASSERT_IMP(a_lead_range, clk_i, rst_ni, need_q != 3'd0,
                    lead_q >= LeadMin && lead_q < NonLeadMin,
                    "pending lead byte out of range")

endmodule
`default_nettype wire

@@ sv/utf8d_queue.sv @@
// Short job queue between the front end and the result sequencer.
`default_nettype none
`include "utf8_stream_decoder_assert.svh"
module utf8d_queue #(
  parameter int unsigned Depth = utf8d_pkg::QueueDepth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  utf8d_pkg::utf8d_job_t job_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  valid_o,
  output utf8d_pkg::utf8d_job_t head_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utf8d_job_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `UTF8D_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Depth), "queue count overflow")
  `UTF8D_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i, "push into full queue")
  `UTF8D_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, !valid_o, !pop_i, "pop from empty queue")

endmodule
`default_nettype wire

@@ sv/utf8d_back.sv @@
// Back end: expands each queued job into results, one per cycle while not stalled, into the output register.
`default_nettype none
`include "utf8_stream_decoder_assert.svh"
module utf8d_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   head_valid_i,
  input  utf8d_pkg::utf8d_job_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [30:0]           code_point_o,
  output logic                  last_of_run_o
);
  import utf8d_pkg::*;

  logic [2:0]  idx_q, idx_d;
  logic        vld_q, vld_d;
  logic [30:0] cp_q;
  logic        last_q;
  logic [2:0]  total;
  logic [2:0]  dsel;
  logic [5:0]  grp;
  logic [30:0] item;
  logic        item_last;
  logic        load;

  assign total     = head_i.flush_n + 3'(head_i.tail_v);
  assign item_last = (idx_q == total - 3'd1);
  assign dsel      = head_i.flush_n - 3'd1 - idx_q;
  assign load      = head_valid_i && (!vld_q || !out_stall_i);
  assign pop_o     = load && item_last;

  always_comb begin
    case (dsel)
      3'd0:    grp = head_i.payload[5:0];
      3'd1:    grp = head_i.payload[11:6];
      3'd2:    grp = head_i.payload[17:12];
      3'd3:    grp = head_i.payload[23:18];
      3'd4:    grp = head_i.payload[29:24];
      default: grp = '0;
    endcase
  end

  // raw lead first, then continuations oldest first, then the final value
  always_comb begin
    if (idx_q >= head_i.flush_n) item = head_i.tail;
    else if (idx_q == 3'd0) item = 31'(head_i.lead);
    else item = 31'(ContMark | {2'b00, grp});
  end

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
      idx_d = item_last ? 3'd0 : idx_q + 3'd1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= item;
      last_q <= item_last;
    end
  end

  assign out_valid_o   = vld_q;
  assign code_point_o  = cp_q;
  assign last_of_run_o = last_q;

  `UTF8D_ASSERT_IMP(a_idx_range, clk_i, rst_ni, head_valid_i, idx_q < total,
                    "result index past end of job")
  `UTF8D_ASSERT_IMP(a_idle_idx, clk_i, rst_ni, !head_valid_i, idx_q == 3'd0,
                    "result index held with no job")

endmodule
`default_nettype wire

@@ sv/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder (legacy forms of up to six bytes).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_byte_i, end_of_string_i
//  out     | source    | out_valid_o/out_stall_i | code_point_o, last_of_run_o
//
// One byte per cycle is taken while the job queue has room; a byte causes 0 to 6 results.
// The output register gives one result per cycle while out_stall_i is low; a job holds its
// queue entry until its last result is loaded, and input stalls while the queue is full.
// An accepted byte's results pass through the job queue and then the output register.
// Reset clears the pending sequence, empties the queue and clears the output valid flag.
`default_nettype none
module utf8_stream_decoder #(
  parameter int unsigned QDepth = utf8d_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  in_byte_i,
  input  wire         end_of_string_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [30:0] code_point_o,
  output logic        last_of_run_o
);
  import utf8d_pkg::*;

  utf8d_job_t job, head;
  logic       push, pop, q_full, q_valid;

  utf8d_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .end_of_string_i,
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  utf8d_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  utf8d_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .code_point_o,
    .last_of_run_o
  );

endmodule
`default_nettype wire
